@@ sv/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_HOLDS(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/frdr_pkg.sv @@
// Package: constants, register codes and the coordinate wrap table builder of the dirty-rectangle core.
`default_nettype none

package frdr_pkg;

  // Default frame store geometry
  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  // Field widths
  localparam int unsigned PIXEL_W   = 32;
  localparam int unsigned COORD_W   = 8;
  localparam int unsigned SIZE_W    = 9;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 9;

  // Number of distinct coordinate codes and width of a wrapped coordinate
  localparam int unsigned COORD_SPAN = 256;
  localparam int unsigned MOD_W      = 12;

  // Reset and fill values
  localparam logic [PIXEL_W-1:0] STORE_FILL = 32'hA5A5A5A5;
  localparam logic [SIZE_W-1:0]  SIZE_RESET = 9'd240;
  localparam logic [SIZE_W-1:0]  VIS_MIN    = 9'd1;
  localparam logic [SIZE_W-1:0]  VIS_MAX    = 9'd256;
  localparam logic [COORD_W-1:0] BOX_LOW_RESET  = 8'd255;
  localparam logic [COORD_W-1:0] BOX_HIGH_RESET = 8'd0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_IS_WIDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_FRAME    = 3'd3;

  // Build a table of c mod m for every coordinate code c, by counting with wrap
  function automatic logic [COORD_SPAN-1:0][MOD_W-1:0] mod_table(input int unsigned m);
    logic [COORD_SPAN-1:0][MOD_W-1:0] t;
    int unsigned r;
    r = 0;
    for (int i = 0; i < COORD_SPAN; i++) begin
      t[i] = MOD_W'(r);
      r = (r + 1 == m) ? 0 : r + 1;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

@@ sv/frdr_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module frdr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port: old data on a same-address write, hold when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/frame_dirty_rect_detector_core.sv @@
// Frame dirty-rectangle detector: frame store diff and bounding box of changed pixels.
//
// Takes one pixel per clock, sustained, with no gaps between frames, while no
// frame-end result waits on a stalled output. Each pixel is read from the store
// in the cycle it is transferred, then compared and written back from the compare
// stage, so the store's single read and single write port set that rate; a pixel
// hitting the entry written in the same cycle takes the written word by forwarding.
// The result for a frame-end pixel is registered from the compare stage into the
// result register. After reset the store is filled with 0xA5A5A5A5, one word a
// cycle, over all MAX_WIDTH * MAX_HEIGHT words (65536 at the defaults); in_ready
// stays low during that fill, while configuration writes are taken throughout.
`default_nettype none

module frame_dirty_rect_detector_core #(
  parameter int unsigned MAX_WIDTH  = frdr_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = frdr_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Configuration write channel
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [frdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [frdr_pkg::CFG_DAT_W-1:0] cfg_data,
  // Pixel channel
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [frdr_pkg::PIXEL_W-1:0]   pixel,
  input  wire logic [frdr_pkg::COORD_W-1:0]   column,
  input  wire logic [frdr_pkg::COORD_W-1:0]   row,
  input  wire logic                           frame_end,
  // Result channel
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic                           changed,
  output      logic [frdr_pkg::COORD_W-1:0]   left,
  output      logic [frdr_pkg::COORD_W-1:0]   top,
  output      logic [frdr_pkg::COORD_W-1:0]   right,
  output      logic [frdr_pkg::COORD_W-1:0]   bottom
);

  import frdr_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam logic [COORD_SPAN-1:0][MOD_W-1:0] COL_WRAP = mod_table(MAX_WIDTH);
  localparam logic [COORD_SPAN-1:0][MOD_W-1:0] ROW_WRAP = mod_table(MAX_HEIGHT);

  // Configuration registers
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic              pixel_is_wide;
  logic              full_frame;

  // Store fill after reset
  logic          clearing;
  logic [AW-1:0] clear_addr;

  // Compare stage
  logic               s1_valid;
  logic [PIXEL_W-1:0] s1_pixel;
  logic [AW-1:0]      s1_addr;
  logic [COORD_W-1:0] s1_col;
  logic [COORD_W-1:0] s1_row;
  logic               s1_last;
  logic               s1_in_area;
  logic               s1_fwd_hit;
  logic [PIXEL_W-1:0] s1_fwd_data;

  // Bounding box
  logic [COORD_W-1:0] box_left;
  logic [COORD_W-1:0] box_top;
  logic [COORD_W-1:0] box_right;
  logic [COORD_W-1:0] box_bottom;
  logic               any_change;
  logic [COORD_W-1:0] box_left_next;
  logic [COORD_W-1:0] box_top_next;
  logic [COORD_W-1:0] box_right_next;
  logic [COORD_W-1:0] box_bottom_next;
  logic               any_change_next;

  logic [SIZE_W-1:0]  vis_width;
  logic [SIZE_W-1:0]  vis_height;
  logic [SIZE_W-1:0]  vis_right;
  logic [SIZE_W-1:0]  vis_bottom;
  logic [CW-1:0]      col_wrap;
  logic [RW-1:0]      row_wrap;
  logic [AW-1:0]      in_addr;
  logic               in_area;
  logic               in_fire;
  logic               s1_adv;
  logic               wr_stage;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [PIXEL_W-1:0] ram_wdata;
  logic [PIXEL_W-1:0] ram_rdata;
  logic [PIXEL_W-1:0] prev_word;
  logic [PIXEL_W-1:0] diff_bits;
  logic               pix_diff;

  // Take configuration writes at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= SIZE_RESET;
      frame_height  <= SIZE_RESET;
      pixel_is_wide <= 1'b1;
      full_frame    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        REG_PIXEL_IS_WIDE: pixel_is_wide <= cfg_data[0];
        REG_FULL_FRAME:    full_frame    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Saturate the visible size to the legal range
  assign vis_width  = (frame_width == '0) ? VIS_MIN :
                      (frame_width > VIS_MAX) ? VIS_MAX : frame_width;
  assign vis_height = (frame_height == '0) ? VIS_MIN :
                      (frame_height > VIS_MAX) ? VIS_MAX : frame_height;
  assign vis_right  = vis_width - VIS_MIN;
  assign vis_bottom = vis_height - VIS_MIN;

  // Store address of the incoming pixel
  assign col_wrap = COL_WRAP[column][CW-1:0];
  assign row_wrap = ROW_WRAP[row][RW-1:0];
  assign in_addr  = AW'(row_wrap) * AW'(MAX_WIDTH) + AW'(col_wrap);
  assign in_area  = ({1'b0, column} < vis_width) && ({1'b0, row} < vis_height);

  // Compare stage advances unless a frame-end result has nowhere to go
  assign s1_adv   = !s1_valid || !s1_last || !out_valid || out_ready;
  assign in_ready = !clearing && s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign wr_stage = s1_valid && s1_adv && s1_in_area;

  // Fill the store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Frame store port selection
  assign ram_we    = clearing || wr_stage;
  assign ram_waddr = clearing ? clear_addr : s1_addr;
  assign ram_wdata = clearing ? STORE_FILL : s1_pixel;

  frdr_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // Advance the compare stage, capturing a same-cycle write for forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel    <= pixel;
      s1_addr     <= in_addr;
      s1_col      <= column;
      s1_row      <= row;
      s1_last     <= frame_end;
      s1_in_area  <= in_area;
      s1_fwd_hit  <= wr_stage && (s1_addr == in_addr);
      s1_fwd_data <= s1_pixel;
    end
  end

  // Compare against the previous frame's word
  assign prev_word = s1_fwd_hit ? s1_fwd_data : ram_rdata;
  assign diff_bits = prev_word ^ s1_pixel;
  assign pix_diff  = s1_in_area && (pixel_is_wide ? |diff_bits : |diff_bits[15:0]);

  // Grow the box around a changed pixel
  always_comb begin
    box_left_next   = box_left;
    box_top_next    = box_top;
    box_right_next  = box_right;
    box_bottom_next = box_bottom;
    any_change_next = any_change;
    if (pix_diff) begin
      if (s1_col < box_left)   box_left_next   = s1_col;
      if (s1_col > box_right)  box_right_next  = s1_col;
      if (s1_row < box_top)    box_top_next    = s1_row;
      if (s1_row > box_bottom) box_bottom_next = s1_row;
      any_change_next = 1'b1;
    end
  end

  // Update the box; clear it at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      box_left   <= BOX_LOW_RESET;
      box_top    <= BOX_LOW_RESET;
      box_right  <= BOX_HIGH_RESET;
      box_bottom <= BOX_HIGH_RESET;
      any_change <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      if (s1_last) begin
        box_left   <= BOX_LOW_RESET;
        box_top    <= BOX_LOW_RESET;
        box_right  <= BOX_HIGH_RESET;
        box_bottom <= BOX_HIGH_RESET;
        any_change <= 1'b0;
      end else begin
        box_left   <= box_left_next;
        box_top    <= box_top_next;
        box_right  <= box_right_next;
        box_bottom <= box_bottom_next;
        any_change <= any_change_next;
      end
    end
  end

  // Result register: load at frame end, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv && s1_last) begin
      if (full_frame) begin
        changed <= 1'b1;
        left    <= '0;
        top     <= '0;
        right   <= vis_right[COORD_W-1:0];
        bottom  <= vis_bottom[COORD_W-1:0];
      end else if (any_change_next) begin
        changed <= 1'b1;
        left    <= box_left_next;
        top     <= box_top_next;
        right   <= box_right_next;
        bottom  <= box_bottom_next;
      end else begin
        changed <= 1'b0;
        left    <= '0;
        top     <= '0;
        right   <= '0;
        bottom  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/frdr_checker.sv @@
// Port-level checker for the dirty-rectangle core, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module frdr_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic                           changed,
  input wire logic [frdr_pkg::COORD_W-1:0]   left,
  input wire logic [frdr_pkg::COORD_W-1:0]   top,
  input wire logic [frdr_pkg::COORD_W-1:0]   right,
  input wire logic [frdr_pkg::COORD_W-1:0]   bottom
);

  // A pending result stays until transferred
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // An unchanged frame reports an empty box
  `ASSERT_HOLDS(a_skip_zero, clk, rst, out_valid && !changed, (left | top | right | bottom) == '0)

  // A reported box is never inverted
  `ASSERT_HOLDS(a_box_order, clk, rst, out_valid && changed, (left <= right) && (top <= bottom))

  // The store fill keeps pixels out right after reset
  `ASSERT_HOLDS(a_fill_blocks, clk, rst, $past(rst), !in_ready && !out_valid)

endmodule

bind frame_dirty_rect_detector_core frdr_checker u_frdr_checker (.*);

`default_nettype wire

@@ verif/frdr_rect_checker.sv @@
// Checker for the dirty-rectangle core: tracks transfers, predicts each frame result, compares.
`default_nettype none

module frdr_rect_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [frdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [frdr_pkg::CFG_DAT_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic [frdr_pkg::PIXEL_W-1:0]   pixel,
  input  wire logic [frdr_pkg::COORD_W-1:0]   column,
  input  wire logic [frdr_pkg::COORD_W-1:0]   row,
  input  wire logic                           frame_end,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic                           changed,
  input  wire logic [frdr_pkg::COORD_W-1:0]   left,
  input  wire logic [frdr_pkg::COORD_W-1:0]   top,
  input  wire logic [frdr_pkg::COORD_W-1:0]   right,
  input  wire logic [frdr_pkg::COORD_W-1:0]   bottom,
  output int                                  errors,
  output int                                  pending
);
  import frdr_pkg::*;

  localparam logic [PIXEL_W-1:0] WIDE_MASK   = 32'hFFFF_FFFF;
  localparam logic [PIXEL_W-1:0] NARROW_MASK = 32'h0000_FFFF;

  typedef struct packed {
    logic               changed;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } rect_t;

  // Shadow of the frame store and the running dirty box
  logic [PIXEL_W-1:0] shadow_frame [0:COORD_SPAN*COORD_SPAN-1];
  logic [SIZE_W-1:0]  width_reg;
  logic [SIZE_W-1:0]  height_reg;
  logic               wide_reg;
  logic               full_reg;
  logic [COORD_W-1:0] dirty_left;
  logic [COORD_W-1:0] dirty_top;
  logic [COORD_W-1:0] dirty_right;
  logic [COORD_W-1:0] dirty_bottom;
  logic               dirty_any;
  rect_t              expected_rects [$];

  // Saturate a size register to the visible range
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    if (v < VIS_MIN) return VIS_MIN;
    if (v > VIS_MAX) return VIS_MAX;
    return v;
  endfunction

  task automatic clear_dirty_box();
    dirty_left   = BOX_LOW_RESET;
    dirty_top    = BOX_LOW_RESET;
    dirty_right  = BOX_HIGH_RESET;
    dirty_bottom = BOX_HIGH_RESET;
    dirty_any    = 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : observe
    rect_t             got;
    rect_t             want;
    rect_t             done_rect;
    logic [SIZE_W-1:0] vis_w;
    logic [SIZE_W-1:0] vis_h;
    logic [PIXEL_W-1:0] mask;
    if (rst) begin
      for (int i = 0; i < COORD_SPAN * COORD_SPAN; i++) shadow_frame[i] = STORE_FILL;
      width_reg  = SIZE_RESET;
      height_reg = SIZE_RESET;
      wide_reg   = 1'b1;
      full_reg   = 1'b0;
      clear_dirty_box();
      expected_rects.delete();
    end else begin
      // Compare a result transfer with the oldest expectation
      if (out_valid && out_ready) begin
        got = {changed, left, top, right, bottom};
        if (expected_rects.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, got changed %0d box %0d,%0d,%0d,%0d",
                   $time, got.changed, got.left, got.top, got.right, got.bottom);
        end else begin
          want = expected_rects.pop_front();
          check_field("changed", want.changed, got.changed);
          check_field("left", want.left, got.left);
          check_field("top", want.top, got.top);
          check_field("right", want.right, got.right);
          check_field("bottom", want.bottom, got.bottom);
        end
      end
      // Register write transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            width_reg = cfg_data;
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_data;
          end
          REG_PIXEL_IS_WIDE: begin
            wide_reg = cfg_data[0];
          end
          REG_FULL_FRAME: begin
            full_reg = cfg_data[0];
          end
          default: ;
        endcase
      end
      // Pixel transfer: diff against the shadow store and grow the box
      if (in_valid && in_ready) begin
        vis_w = clamp_size(width_reg);
        vis_h = clamp_size(height_reg);
        if ({1'b0, column} < vis_w && {1'b0, row} < vis_h) begin
          mask = wide_reg ? WIDE_MASK : NARROW_MASK;
          if (((shadow_frame[{row, column}] ^ pixel) & mask) != '0) begin
            if (column < dirty_left) dirty_left = column;
            if (column > dirty_right) dirty_right = column;
            if (row < dirty_top) dirty_top = row;
            if (row > dirty_bottom) dirty_bottom = row;
            dirty_any = 1'b1;
          end
          shadow_frame[{row, column}] = pixel;
        end
        // Close the frame: full area, the dirty box, or nothing changed
        if (frame_end) begin
          done_rect = '0;
          if (full_reg) begin
            done_rect.changed = 1'b1;
            done_rect.right   = COORD_W'(vis_w - 1'b1);
            done_rect.bottom  = COORD_W'(vis_h - 1'b1);
          end else if (dirty_any) begin
            done_rect = {1'b1, dirty_left, dirty_top, dirty_right, dirty_bottom};
          end
          expected_rects.push_back(done_rect);
          clear_dirty_box();
        end
      end
    end
    pending = expected_rects.size();
  end

endmodule

`default_nettype wire

@@ verif/frame_dirty_rect_detector_core_tb.sv @@
// Testbench top: drives frames and register writes into the dirty-rectangle core, gives the verdict.
`default_nettype none

module frame_dirty_rect_detector_core_tb;
  import frdr_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 4;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_CYCLES     = 300;
  localparam int RANDOM_ITEMS    = 700;
  localparam int PHASES_PER_MODE = 4;
  localparam int MODE_COUNT      = 3;
  localparam int TIMEOUT         = 4_000_000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [PIXEL_W-1:0]   pixel     = '0;
  logic [COORD_W-1:0]   column    = '0;
  logic [COORD_W-1:0]   row       = '0;
  logic                 frame_end = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 changed;
  logic [COORD_W-1:0]   left;
  logic [COORD_W-1:0]   top;
  logic [COORD_W-1:0]   right;
  logic [COORD_W-1:0]   bottom;
  int                   errors;
  int                   pending;

  // Idle rates, hold-off requests and the last pixel sent to each position
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   hold_req      = 0;
  int                   hold_seen     = 0;
  int                   items_sent    = 0;
  logic [PIXEL_W-1:0]   scene [0:COORD_SPAN*COORD_SPAN-1];

  frame_dirty_rect_detector_core u_dut (.*);

  frdr_rect_checker u_checker (.*);

  always #HALF_PERIOD clk = ~clk;

  // Hard stop if the run hangs
  initial begin
    #(TIMEOUT);
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stalls, or a long hold-off when one is requested
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_seen = hold_req;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one pixel, with random gaps ahead of it, and hold it until the transfer
  task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic [COORD_W-1:0] col,
                            input logic [COORD_W-1:0] rw, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    pixel     <= pix;
    column    <= col;
    row       <= rw;
    frame_end <= last;
    scene[{rw, col}] = pix;
    items_sent++;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Write every register, sometimes with a stray index thrown in
  task automatic program_frame(input logic [SIZE_W-1:0] w_reg, input logic [SIZE_W-1:0] h_reg,
                               input logic wide, input logic full);
    if ($urandom_range(2) == 0)
      write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_FULL_FRAME + 1)),
                CFG_DAT_W'($urandom));
    write_reg(REG_FRAME_WIDTH, w_reg);
    write_reg(REG_FRAME_HEIGHT, h_reg);
    write_reg(REG_PIXEL_IS_WIDE, {(CFG_DAT_W-1)'($urandom), wide});
    write_reg(REG_FULL_FRAME, {(CFG_DAT_W-1)'($urandom), full});
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, let every result arrive and the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly repeat the old pixel, otherwise change high half, one bit, or all of it
  function automatic logic [PIXEL_W-1:0] vary_pixel(input logic [PIXEL_W-1:0] old);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return old;
      5: return {old[31:16] ^ 16'($urandom_range(65535, 1)), old[15:0]};
      6: return old ^ (32'd1 << $urandom_range(31));
      7: return $urandom_range(1) ? '0 : '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_vis();
    case ($urandom_range(9))
      0: return 1;
      1: return VIS_MAX;
      2: return $urandom_range(255, 9);
      default: return $urandom_range(8, 1);
    endcase
  endfunction

  // Register value for a visible size, sometimes one that saturates to it
  function automatic logic [SIZE_W-1:0] size_reg(input int vis);
    if (vis == 1 && $urandom_range(3) == 0) return '0;
    if (vis == VIS_MAX && $urandom_range(1) == 1) return SIZE_W'($urandom_range(511, 257));
    return SIZE_W'(vis);
  endfunction

  // Scan a small window of the visible area; sometimes overscan the edge or cut the frame short
  task automatic scan_window(input int vis_w, input int vis_h);
    int sw;
    int sh;
    int c0;
    int r0;
    int cols;
    int rows;
    int stop;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] rw;
    sw   = $urandom_range((vis_w < 6) ? vis_w : 6, 1);
    sh   = $urandom_range((vis_h < 5) ? vis_h : 5, 1);
    c0   = $urandom_range(vis_w - sw, 0);
    r0   = $urandom_range(vis_h - sh, 0);
    cols = sw;
    rows = sh;
    if (c0 + sw == vis_w && vis_w < COORD_SPAN && $urandom_range(3) == 0) cols = sw + 1;
    if (r0 + sh == vis_h && vis_h < COORD_SPAN && $urandom_range(3) == 0) rows = sh + 1;
    stop = ($urandom_range(6) == 0) ? $urandom_range(rows * cols - 1, 0) : rows * cols - 1;
    for (int k = 0; k <= stop; k++) begin
      col = COORD_W'(c0 + k % cols);
      rw  = COORD_W'(r0 + k / cols);
      send_pixel(vary_pixel(scene[{rw, col}]), col, rw, k == stop);
    end
  endtask

  initial begin : stimulus
    int vis_w;
    int vis_h;
    int phase_goal;
    bit held;
    held = 1'b0;
    for (int i = 0; i < COORD_SPAN * COORD_SPAN; i++) scene[i] = STORE_FILL;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 2x2 frame against the filled store: extremes, an unchanged word, an off-area pixel
    program_frame(9'd2, 9'd2, 1'b1, 1'b0);
    send_pixel(32'h0000_0000, 8'd0, 8'd0, 1'b0);
    send_pixel(STORE_FILL, 8'd1, 8'd0, 1'b0);
    send_pixel(32'h1234_5678, 8'd255, 8'd255, 1'b0);
    send_pixel(32'hFFFF_FFFF, 8'd0, 8'd1, 1'b0);
    send_pixel(STORE_FILL, 8'd1, 8'd1, 1'b1);
    // Same frame again, ended by an off-area pixel: nothing changed
    send_pixel(32'h0000_0000, 8'd0, 8'd0, 1'b0);
    send_pixel(STORE_FILL, 8'd1, 8'd0, 1'b0);
    send_pixel(32'hFFFF_FFFF, 8'd0, 8'd1, 1'b0);
    send_pixel(STORE_FILL, 8'd1, 8'd1, 1'b0);
    send_pixel(32'hDEAD_BEEF, 8'd255, 8'd0, 1'b1);
    // Narrow compare: high-half change ignored, low-half change seen
    wait_drained();
    program_frame(9'd2, 9'd2, 1'b0, 1'b0);
    send_pixel(32'hFFFF_0000, 8'd0, 8'd0, 1'b0);
    send_pixel(32'hA5A5_0000, 8'd1, 8'd1, 1'b1);
    // Full-frame with width below range and height above it
    wait_drained();
    program_frame(9'd0, 9'd511, 1'b1, 1'b1);
    send_pixel(32'h0000_0000, 8'd1, 8'd0, 1'b0);
    send_pixel(32'h0000_0000, 8'd0, 8'd255, 1'b1);
    // Largest area: wide compare sees the full word stored in narrow mode
    wait_drained();
    program_frame(9'd256, 9'd256, 1'b1, 1'b0);
    send_pixel(32'h0000_0000, 8'd0, 8'd0, 1'b0);
    send_pixel(32'hFFFF_FFFF, 8'd255, 8'd255, 1'b1);
    // Single-pixel area, no change
    wait_drained();
    program_frame(9'd1, 9'd1, 1'b1, 1'b0);
    send_pixel(32'h0000_0000, 8'd0, 8'd0, 1'b1);

    // Random phases: receiver idles more, then sender, then neither
    for (int mode = 0; mode < MODE_COUNT; mode++) begin
      send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 62 : 0;
      recv_idle_pct = (mode == 0) ? 62 : (mode == 1) ? 32 : 0;
      repeat (PHASES_PER_MODE) begin
        vis_w = pick_vis();
        vis_h = pick_vis();
        wait_drained();
        program_frame(size_reg(vis_w), size_reg(vis_h), 1'($urandom_range(1)),
                      $urandom_range(4) == 0);
        // Hold the result side off while pixels keep coming
        if (mode == MODE_COUNT - 1 && !held) begin
          hold_req++;
          held = 1'b1;
        end
        phase_goal = items_sent + RANDOM_ITEMS / (MODE_COUNT * PHASES_PER_MODE);
        while (items_sent < phase_goal) begin
          if ($urandom_range(4) != 0)
            scan_window(vis_w, vis_h);
          else
            send_pixel($urandom, COORD_W'($urandom), COORD_W'($urandom),
                       $urandom_range(7) == 0);
        end
      end
    end

    wait_drained();
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+sv
sv/frdr_pkg.sv
sv/frdr_ram.sv
sv/frame_dirty_rect_detector_core.sv
sv/frdr_checker.sv
verif/frdr_rect_checker.sv
verif/frame_dirty_rect_detector_core_tb.sv
